// ===== hdl/dtf_pkg.sv =====
package dtf_pkg;

	// number format
	localparam int FRAC_BITS       = 16;
	localparam int INT_BITS        = 16;
	localparam int MAX_FRAC_DIGITS = 9;

	localparam int VALUE_W = 32;
	localparam int STATUS_W = 2;
	localparam int CH_W = 8;

	// integer magnitude without the sign bit
	localparam int IACC_W = INT_BITS - 1;
	// fraction digits and the matching power of ten
	localparam int FACC_W = $clog2(10 ** MAX_FRAC_DIGITS + 1);
	localparam int FCNT_W = $clog2(MAX_FRAC_DIGITS + 1);
	localparam int MAG_W  = IACC_W + FRAC_BITS;
	localparam int WIDE_W = (MAG_W + 1 > VALUE_W) ? MAG_W + 1 : VALUE_W;
	localparam int DCNT_W = $clog2(FRAC_BITS + 1);

	localparam logic [WIDE_W-1:0] SAT_POS = {{(WIDE_W - MAG_W){1'b0}}, {MAG_W{1'b1}}};
	localparam logic [WIDE_W-1:0] SAT_NEG = ~SAT_POS;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_SYNTAX = 2'd1;
	localparam logic [STATUS_W-1:0] ST_SAT    = 2'd2;

	localparam logic [CH_W-1:0] CH_NUL   = 8'd0;
	localparam logic [CH_W-1:0] CH_TAB   = 8'd9;
	localparam logic [CH_W-1:0] CH_CR    = 8'd13;
	localparam logic [CH_W-1:0] CH_SPACE = 8'd32;
	localparam logic [CH_W-1:0] CH_COMMA = 8'd44;
	localparam logic [CH_W-1:0] CH_MINUS = 8'd45;
	localparam logic [CH_W-1:0] CH_DOT   = 8'd46;
	localparam logic [CH_W-1:0] CH_ZERO  = 8'd48;
	localparam logic [CH_W-1:0] CH_NINE  = 8'd57;

	typedef enum logic [2:0] {
		PH_LEAD  = 3'd0,
		PH_SIGN  = 3'd1,
		PH_INT   = 3'd2,
		PH_POINT = 3'd3,
		PH_FRAC  = 3'd4,
		PH_TRAIL = 3'd5,
		PH_DIV   = 3'd6
	} phase_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== hdl/decimal_text_to_fixed_unit.sv =====
// channel | words      | handshake           | fields
// --------+------------+---------------------+----------------------------
// ch      | input      | ch_valid / ch_stall | ch
// res     | output     | res_valid/res_stall | value, status, at_text_end
//
// a terminator that completes a number without saturation holds ch_stall while
// the restoring divider forms the fraction, one quotient bit a cycle, and until
// the result register is loaded
// arst_n clears the phase, the accumulators' control flags and the result valid
// a word that yields a result waits while an earlier result sits stalled; every word waits while the divider runs
module decimal_text_to_fixed_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             ch_valid,
	output logic                             ch_stall,
	input  logic [dtf_pkg::CH_W-1:0]         ch,
	output logic                             res_valid,
	input  logic                             res_stall,
	output logic signed [dtf_pkg::VALUE_W-1:0] value,
	output logic [dtf_pkg::STATUS_W-1:0]     status,
	output logic                             at_text_end
);
	import dtf_pkg::*;

	phase_t phase_q;
	phase_t nxt_phase;

	logic               neg_q;
	logic [IACC_W-1:0]  iacc_q;
	logic               ovf_q;
	logic [FACC_W-1:0]  facc_q;
	logic [FACC_W-1:0]  pow_q;
	logic [FCNT_W-1:0]  fcnt_q;
	logic               fin_end_q;

	logic                      out_valid_q;
	logic [VALUE_W-1:0]        value_q;
	logic [STATUS_W-1:0]       status_q;
	logic                      end_q;

	logic is_digit, is_blank, is_term, is_point, is_nul;
	logic [3:0] dig;

	logic act_err, act_finish, act_int, act_frac, act_new, act_neg;
	logic will_emit, accept;

	logic [FRAC_BITS-1:0] quo;
	div_stat_t            dstat;
	logic                 div_start;

	logic [IACC_W-1:0]   iacc_base;
	logic                ovf_base;
	logic [IACC_W+3:0]   inext;
	logic [FACC_W+3:0]   fnext;
	logic [FACC_W+3:0]   pnext;
	logic [WIDE_W-1:0]   mag_ext;
	logic [WIDE_W-1:0]   fix_val;

	assign is_nul   = ch == CH_NUL;
	assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign is_blank = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR);
	assign is_term  = is_nul || (ch == CH_COMMA) || (ch == CH_SPACE) || (ch == CH_TAB);
	assign is_point = (ch == CH_DOT) || (ch == CH_COMMA);
	assign dig      = 4'(ch - CH_ZERO);

	// next phase
	always_comb begin
		nxt_phase = phase_q;
		unique case (phase_q)
			PH_SIGN: nxt_phase = is_digit ? PH_INT : PH_LEAD;
			PH_INT: begin
				priority if (is_digit) nxt_phase = PH_INT;
				else if (is_point)     nxt_phase = PH_POINT;
				else                   nxt_phase = PH_LEAD;
			end
			PH_POINT, PH_FRAC: begin
				priority if (is_digit)                   nxt_phase = PH_FRAC;
				else if (phase_q == PH_FRAC && is_term) begin
					if (ovf_q) nxt_phase = is_nul ? PH_LEAD : PH_TRAIL;
					else       nxt_phase = PH_DIV;
				end else                                 nxt_phase = PH_LEAD;
			end
			PH_DIV: nxt_phase = dstat.done ? (fin_end_q ? PH_LEAD : PH_TRAIL) : PH_DIV;
			default: begin
				priority if (phase_q == PH_TRAIL && is_nul) nxt_phase = PH_LEAD;
				else if (is_blank)                          nxt_phase = phase_q;
				else if (ch == CH_MINUS)                    nxt_phase = PH_SIGN;
				else if (is_digit)                          nxt_phase = PH_INT;
				else                                        nxt_phase = PH_LEAD;
			end
		endcase
	end

	// per-word actions
	always_comb begin
		act_err    = 1'b0;
		act_finish = 1'b0;
		act_int    = 1'b0;
		act_frac   = 1'b0;
		act_new    = 1'b0;
		act_neg    = 1'b0;
		unique case (phase_q)
			PH_SIGN: begin
				act_int = is_digit;
				act_err = !is_digit;
			end
			PH_INT: begin
				act_int = is_digit;
				act_err = !is_digit && !is_point;
			end
			PH_POINT, PH_FRAC: begin
				act_frac   = is_digit;
				act_finish = !is_digit && phase_q == PH_FRAC && is_term;
				act_err    = !is_digit && !(phase_q == PH_FRAC && is_term);
			end
			PH_DIV: ;
			default: begin
				if (!(phase_q == PH_TRAIL && is_nul) && !is_blank) begin
					act_new = (ch == CH_MINUS) || is_digit;
					act_neg = ch == CH_MINUS;
					act_int = is_digit;
					act_err = (ch != CH_MINUS) && !is_digit;
				end
			end
		endcase
	end

	assign will_emit = act_err || act_finish;
	assign ch_stall  = (phase_q == PH_DIV) || (out_valid_q && res_stall && will_emit);
	assign accept    = ch_valid && !ch_stall;
	assign div_start = accept && act_finish && !ovf_q;

	// digit accumulation, times ten as shift and add
	assign iacc_base = act_new ? '0 : iacc_q;
	assign ovf_base  = act_new ? 1'b0 : ovf_q;
	assign inext = {1'b0, iacc_base, 3'b000} + {3'b000, iacc_base, 1'b0} + (IACC_W+4)'(dig);
	assign fnext = {1'b0, facc_q, 3'b000} + {3'b000, facc_q, 1'b0} + (FACC_W+4)'(dig);
	assign pnext = {1'b0, pow_q, 3'b000} + {3'b000, pow_q, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			neg_q   <= 1'b0;
			ovf_q   <= 1'b0;
			fcnt_q  <= '0;
			iacc_q  <= '0;
			facc_q  <= '0;
			pow_q   <= FACC_W'(1);
			fin_end_q <= 1'b0;
		end else if (phase_q == PH_DIV) begin
			phase_q <= nxt_phase;
		end else if (accept) begin
			phase_q <= nxt_phase;
			if (act_err || act_new) begin
				neg_q  <= act_neg;
				ovf_q  <= 1'b0;
				fcnt_q <= '0;
				iacc_q <= '0;
				facc_q <= '0;
				pow_q  <= FACC_W'(1);
			end
			if (act_int) begin
				if (ovf_base || inext > (IACC_W+4)'({IACC_W{1'b1}})) begin
					ovf_q  <= 1'b1;
					iacc_q <= {IACC_W{1'b1}};
				end else begin
					ovf_q  <= 1'b0;
					iacc_q <= inext[IACC_W-1:0];
				end
			end
			if (act_frac && fcnt_q < FCNT_W'(MAX_FRAC_DIGITS)) begin
				facc_q <= fnext[FACC_W-1:0];
				pow_q  <= pnext[FACC_W-1:0];
				fcnt_q <= fcnt_q + FCNT_W'(1);
			end
			if (act_finish) begin
				fin_end_q <= is_nul;
			end
		end
	end

	dtf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (facc_q),
		.divisor  (pow_q),
		.quotient (quo),
		.stat     (dstat)
	);

	assign mag_ext = {{(WIDE_W - MAG_W){1'b0}}, iacc_q, quo};
	assign fix_val = neg_q ? (~mag_ext + WIDE_W'(1)) : mag_ext;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((accept && will_emit && !div_start) || dstat.done) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dstat.done) begin
			value_q  <= fix_val[VALUE_W-1:0];
			status_q <= ST_OK;
			end_q    <= fin_end_q;
		end else if (accept && act_err) begin
			value_q  <= '0;
			status_q <= ST_SYNTAX;
			end_q    <= is_nul;
		end else if (accept && act_finish && ovf_q) begin
			value_q  <= neg_q ? SAT_NEG[VALUE_W-1:0] : SAT_POS[VALUE_W-1:0];
			status_q <= ST_SAT;
			end_q    <= is_nul;
		end
	end

	assign res_valid   = out_valid_q;
	assign value       = value_q;
	assign status      = status_q;
	assign at_text_end = end_q;

endmodule

// ===== hdl/dtf_div.sv =====
module dtf_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [dtf_pkg::FACC_W-1:0]      dividend,
	input  logic [dtf_pkg::FACC_W-1:0]      divisor,
	output logic [dtf_pkg::FRAC_BITS-1:0]   quotient,
	output dtf_pkg::div_stat_t              stat
);
	import dtf_pkg::*;

	logic [FACC_W-1:0]    rem_q;
	logic [FACC_W-1:0]    dvs_q;
	logic [FRAC_BITS-1:0] quo_q;
	logic [DCNT_W-1:0]    cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [FACC_W:0] trial;
	logic [FACC_W:0] diff;
	logic            fits;

	// restoring step: remainder stays below the divisor
	assign trial = {rem_q, 1'b0};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DCNT_W'(1);
				if (cnt_q == DCNT_W'(FRAC_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dvs_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[FACC_W-1:0] : trial[FACC_W-1:0];
			quo_q <= {quo_q[FRAC_BITS-2:0], fits};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== hdl/dtf_checker.sv =====
module dtf_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         ch_valid,
	input  logic                         ch_stall,
	input  logic [dtf_pkg::CH_W-1:0]     ch,
	input  logic                         res_valid,
	input  logic                         res_stall,
	input  logic [dtf_pkg::VALUE_W-1:0]  value,
	input  logic [dtf_pkg::STATUS_W-1:0] status,
	input  logic                         at_text_end
);
	import dtf_pkg::*;

	// a syntax error word carries a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_SYNTAX |-> value == '0)
		else $error("syntax error word with nonzero value");

	// saturated words carry one of the two bounds
	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_SAT |->
		value == SAT_POS[VALUE_W-1:0] || value == SAT_NEG[VALUE_W-1:0])
		else $error("saturated word off the bound");

	// status code three is never produced
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> status == ST_OK || status == ST_SYNTAX || status == ST_SAT)
		else $error("undefined status code");

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(value) && $stable(status)
		&& $stable(at_text_end))
		else $error("stalled result word changed");

	// a zero code accepted with no stall while no result is out: a result then raised carries at_text_end
	a_nul_blank: assert property (@(posedge clk) disable iff (!arst_n)
		ch_valid && !ch_stall && ch == CH_NUL && !res_valid |=> !res_valid || at_text_end)
		else $error("result after end of text not flagged");

endmodule

bind decimal_text_to_fixed_unit dtf_checker u_dtf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.ch_valid    (ch_valid),
	.ch_stall    (ch_stall),
	.ch          (ch),
	.res_valid   (res_valid),
	.res_stall   (res_stall),
	.value       (value),
	.status      (status),
	.at_text_end (at_text_end)
);

// ===== sim/tb_decimal_text_to_fixed_unit.sv =====
module tb_decimal_text_to_fixed_unit;
	import dtf_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_WORDS = 1350;
	// stands for the end-of-text code inside string literals
	localparam logic [CH_W-1:0] NUL_MARK = "$";

	typedef struct {
		logic [VALUE_W-1:0]  value;
		logic [STATUS_W-1:0] status;
		logic                at_end;
	} number_t;

	logic                       clk;
	logic                       arst_n;
	logic                       ch_valid;
	logic                       ch_stall;
	logic [CH_W-1:0]            ch;
	logic                       res_valid;
	logic                       res_stall;
	logic signed [VALUE_W-1:0]  value;
	logic [STATUS_W-1:0]        status;
	logic                       at_text_end;

	decimal_text_to_fixed_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.ch_valid(ch_valid),
		.ch_stall(ch_stall),
		.ch(ch),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.value(value),
		.status(status),
		.at_text_end(at_text_end)
	);

	// parser state mirrored on the testbench side
	phase_t             ps_phase;
	logic               ps_neg;
	logic [15:0]        ps_int;
	logic               ps_ovf;
	logic [29:0]        ps_frac;
	logic [3:0]         ps_fcnt;

	number_t            expected_numbers[$];
	int                 errors;
	int                 words_sent;
	int                 burst_left;
	int                 idle_cycles;
	bit                 quiet;
	bit                 stall_on;
	int                 stall_left;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void clear_number();
		ps_neg = 1'b0;
		ps_int = '0;
		ps_ovf = 1'b0;
		ps_frac = '0;
		ps_fcnt = '0;
	endfunction

	function automatic bit is_digit(input logic [CH_W-1:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic void add_int_digit(input logic [CH_W-1:0] c);
		logic [31:0] limit;
		logic [31:0] next;
		limit = (32'd1 << (INT_BITS - 1)) - 32'd1;
		next = 32'(ps_int) * 32'd10 + 32'(c - CH_ZERO);
		if (ps_ovf || next > limit) begin
			ps_ovf = 1'b1;
			ps_int = limit[15:0];
		end else begin
			ps_int = next[15:0];
		end
	endfunction

	function automatic void syntax_fail(input logic [CH_W-1:0] c, output number_t r);
		clear_number();
		ps_phase = PH_LEAD;
		r.value = '0;
		r.status = ST_SYNTAX;
		r.at_end = (c == CH_NUL);
	endfunction

	function automatic void close_number(input logic [CH_W-1:0] c, output number_t r);
		logic [63:0] bound;
		logic [63:0] p10;
		logic [63:0] fx;
		int          n;
		if (ps_ovf) begin
			bound = 64'd1 << (INT_BITS - 1 + FRAC_BITS);
			fx = ps_neg ? (64'd0 - bound) : (bound - 64'd1);
			r.status = ST_SAT;
		end else begin
			n = (int'(ps_fcnt) > 9) ? 9 : int'(ps_fcnt);
			p10 = 64'd1;
			for (int i = 0; i < n; i++)
				p10 = p10 * 64'd10;
			fx = ({34'd0, ps_frac} << FRAC_BITS) / p10;
			fx = fx + ({48'd0, ps_int} << FRAC_BITS);
			if (ps_neg)
				fx = 64'd0 - fx;
			r.status = ST_OK;
		end
		r.value = fx[VALUE_W-1:0];
		r.at_end = (c == CH_NUL);
		clear_number();
		ps_phase = (c == CH_NUL) ? PH_LEAD : PH_TRAIL;
	endfunction

	// advances the mirrored parser by one word, returns 1 when a result word comes out
	function automatic bit parse_char(input logic [CH_W-1:0] c, output number_t r);
		r = '{default: '0};
		case (ps_phase)
			PH_SIGN: begin
				if (!is_digit(c)) begin
					syntax_fail(c, r);
					return 1'b1;
				end
				add_int_digit(c);
				ps_phase = PH_INT;
				return 1'b0;
			end
			PH_INT: begin
				if (is_digit(c)) begin
					add_int_digit(c);
					return 1'b0;
				end
				if (c == CH_DOT || c == CH_COMMA) begin
					ps_phase = PH_POINT;
					return 1'b0;
				end
				syntax_fail(c, r);
				return 1'b1;
			end
			PH_POINT, PH_FRAC: begin
				if (is_digit(c)) begin
					if (ps_fcnt < 4'(MAX_FRAC_DIGITS)) begin
						ps_frac = ps_frac * 30'd10 + 30'(c - CH_ZERO);
						ps_fcnt = ps_fcnt + 4'd1;
					end
					ps_phase = PH_FRAC;
					return 1'b0;
				end
				if (ps_phase == PH_FRAC && (c == CH_NUL || c == CH_COMMA ||
						c == CH_SPACE || c == CH_TAB)) begin
					close_number(c, r);
					return 1'b1;
				end
				syntax_fail(c, r);
				return 1'b1;
			end
			default: begin
				// trailing blanks, leading blanks and the unused codes
				if (ps_phase == PH_TRAIL && c == CH_NUL) begin
					ps_phase = PH_LEAD;
					return 1'b0;
				end
				if (c == CH_SPACE || c == CH_TAB || c == CH_CR)
					return 1'b0;
				if (c == CH_MINUS) begin
					clear_number();
					ps_neg = 1'b1;
					ps_phase = PH_SIGN;
					return 1'b0;
				end
				if (is_digit(c)) begin
					clear_number();
					add_int_digit(c);
					ps_phase = PH_INT;
					return 1'b0;
				end
				syntax_fail(c, r);
				return 1'b1;
			end
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	task automatic send_word(input logic [CH_W-1:0] c);
		int      gap;
		number_t r;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = quiet ? 0 : $urandom_range(0, 16);
			if ($urandom_range(0, 2) == 0)
				gap = 0;
			repeat (gap) begin
				@(negedge clk);
				ch_valid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		ch_valid <= 1'b1;
		ch <= c;
		do @(posedge clk); while (ch_stall);
		words_sent++;
		if (parse_char(c, r))
			expected_numbers.push_back(r);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_word((s[i] == NUL_MARK) ? CH_NUL : s[i]);
	endtask

	function automatic logic [CH_W-1:0] pick_blank();
		case ($urandom_range(0, 2))
			0: return CH_SPACE;
			1: return CH_TAB;
			default: return CH_CR;
		endcase
	endfunction

	function automatic logic [CH_W-1:0] pick_digit();
		return CH_ZERO + CH_W'($urandom_range(0, 9));
	endfunction

	task automatic send_random_number(input bit broken);
		logic [CH_W-1:0] text[$];
		logic [CH_W-1:0] term;
		int              nint;
		int              nfrac;
		int              cut;
		repeat ($urandom_range(0, 2))
			text.push_back(pick_blank());
		if ($urandom_range(0, 1))
			text.push_back(CH_MINUS);
		// mostly short integers, now and then long enough to saturate
		nint = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
		repeat (nint)
			text.push_back(pick_digit());
		text.push_back($urandom_range(0, 1) ? CH_DOT : CH_COMMA);
		nfrac = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 13) : $urandom_range(1, 4);
		repeat (nfrac)
			text.push_back(pick_digit());
		case ($urandom_range(0, 3))
			0: term = CH_NUL;
			1: term = CH_COMMA;
			2: term = CH_SPACE;
			default: term = CH_TAB;
		endcase
		text.push_back(term);
		if (term != CH_NUL) begin
			repeat ($urandom_range(0, 2))
				text.push_back(pick_blank());
			if ($urandom_range(0, 2) == 0)
				text.push_back(CH_NUL);
		end
		if (broken) begin
			cut = $urandom_range(0, text.size() - 1);
			while (text.size() > cut)
				void'(text.pop_back());
			text.push_back(CH_W'($urandom_range(0, 255)));
		end
		foreach (text[i])
			send_word(text[i]);
	endtask

	task automatic test_plain_numbers();
		send_text("0.0$ \r-1,5\t32767.999999999,12.25 ");
	endtask

	task automatic test_syntax_errors();
		send_text("$x-.1.$1 1.5\r");
		send_word(8'hFF);
	endtask

	task automatic test_saturation();
		send_text("32768.5 -99999.0$-32768.0,");
	endtask

	task automatic test_long_fraction();
		send_text("9.0000000005$");
	endtask

	task automatic test_trailing_blanks();
		send_text("2.5 \t\r$4.0 ,");
	endtask

	task automatic test_random_text();
		int start;
		int pick;
		start = words_sent;
		while (words_sent < start + RANDOM_WORDS) begin
			if ($urandom_range(0, 39) == 0)
				quiet = ($urandom_range(0, 2) == 0);
			pick = $urandom_range(0, 19);
			if (pick < 16)
				send_random_number(1'b0);
			else if (pick < 18)
				send_random_number(1'b1);
			else
				send_word(CH_W'($urandom_range(0, 255)));
		end
	endtask

	// receiver stall pattern: runs and stalls of random length
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_on = !quiet && ($urandom_range(0, 2) == 0);
			stall_left = stall_on ? $urandom_range(1, 20) : $urandom_range(1, 25);
		end
		stall_left--;
		res_stall <= stall_on;
	end

	always @(posedge clk) begin
		number_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_numbers.size() == 0) begin
				report_mismatch($sformatf("unexpected result value %h status %0d",
					value, status));
			end else begin
				want = expected_numbers.pop_front();
				if (value !== want.value)
					report_mismatch($sformatf("value %h, expected %h", value, want.value));
				if (status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						status, want.status));
				if (at_text_end !== want.at_end)
					report_mismatch($sformatf("at_text_end %b, expected %b",
						at_text_end, want.at_end));
			end
		end
	end

	// watchdog on cycles in which neither channel moves a word
	always @(posedge clk) begin
		if (!arst_n || (ch_valid && !ch_stall) || (res_valid && !res_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("** decimal_text_to_fixed_unit: FAILED **");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		ch_valid = 1'b0;
		ch = '0;
		res_stall = 1'b0;
		errors = 0;
		words_sent = 0;
		burst_left = 0;
		idle_cycles = 0;
		quiet = 1'b0;
		stall_on = 1'b0;
		stall_left = 0;
		ps_phase = PH_LEAD;
		clear_number();
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		test_plain_numbers();
		test_syntax_errors();
		test_saturation();
		test_long_fraction();
		test_trailing_blanks();
		test_random_text();

		@(negedge clk);
		ch_valid <= 1'b0;
		wait (expected_numbers.size() == 0);
		repeat (FRAC_BITS + 8) @(posedge clk);
		if (errors == 0 && expected_numbers.size() == 0)
			$display("** decimal_text_to_fixed_unit: PASSED **");
		else
			$display("** decimal_text_to_fixed_unit: FAILED **");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/dtf_pkg.sv
hdl/dtf_div.sv
hdl/decimal_text_to_fixed_unit.sv
hdl/dtf_checker.sv
sim/tb_decimal_text_to_fixed_unit.sv
